[rtl/core/pmct_pkg.sv]
// pmct_pkg: shared types and constants of the ps/2 mouse packet cursor tracker
// no dependencies; imported by every module of the block
`default_nettype none

package pmct_pkg;

    localparam int BYTE_W   = 8;
    localparam int DELTA_W  = 9;
    localparam int POS_W    = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = POS_W;
    localparam int OUT_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_Y = 1'b1;

    localparam logic [POS_W-1:0] MAX_X_RESET = 12'd1151;
    localparam logic [POS_W-1:0] MAX_Y_RESET = 12'd863;

    // first byte bit positions
    localparam int B0_LEFT   = 0;
    localparam int B0_RIGHT  = 1;
    localparam int B0_MIDDLE = 2;
    localparam int B0_SYNC   = 3;
    localparam int B0_XSIGN  = 4;
    localparam int B0_YSIGN  = 5;
    localparam int B0_XOVF   = 6;
    localparam int B0_YOVF   = 7;

    // position of the next byte within a packet
    typedef enum logic [1:0] {
        IDX_FIRST  = 2'd0,
        IDX_SECOND = 2'd1,
        IDX_THIRD  = 2'd2
    } byte_idx_t;

    // decoded packet, between the assembler and the cursor stage
    typedef struct packed {
        logic                      left_button;
        logic                      right_button;
        logic                      middle_button;
        logic                      x_overflow;
        logic                      y_overflow;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } pkt_t;

    // one result item
    typedef struct packed {
        pkt_t             pkt;
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/pmct_assembler.sv]
// pmct_assembler: byte framing, first-byte sync check and packet decode
// depends on pmct_pkg; feeds pmct_cursor through a registered packet stage
`default_nettype none

module pmct_assembler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    output logic                              byte_ready,
    input  wire logic [pmct_pkg::BYTE_W-1:0]  data_byte,
    output logic                              pkt_valid,
    input  wire logic                         pkt_ready,
    output pmct_pkg::pkt_t                    pkt
);
    import pmct_pkg::*;

    byte_idx_t          idx_reg, idx_next;
    logic [BYTE_W-1:0]  b0_reg, b1_reg;
    logic               pkt_valid_reg, pkt_valid_next;
    pkt_t               pkt_reg, pkt_next;
    logic               accept;

    assign byte_ready = !pkt_valid_reg || pkt_ready;
    assign accept     = byte_valid && byte_ready;
    assign pkt_valid  = pkt_valid_reg;
    assign pkt        = pkt_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        pkt_valid_next = pkt_valid_reg && !pkt_ready;
        pkt_next.left_button   = b0_reg[B0_LEFT];
        pkt_next.right_button  = b0_reg[B0_RIGHT];
        pkt_next.middle_button = b0_reg[B0_MIDDLE];
        pkt_next.x_overflow    = b0_reg[B0_XOVF];
        pkt_next.y_overflow    = b0_reg[B0_YOVF];
        pkt_next.delta_x       = {b0_reg[B0_XSIGN], b1_reg};
        pkt_next.delta_y       = {b0_reg[B0_YSIGN], data_byte};
        if (accept)
        begin
            case (idx_reg)
                IDX_SECOND: idx_next = IDX_THIRD;
                IDX_THIRD:
                begin
                    idx_next       = IDX_FIRST;
                    pkt_valid_next = 1'b1;
                end
                default:
                    // drop a first byte without the sync bit
                    idx_next = data_byte[B0_SYNC] ? IDX_SECOND : IDX_FIRST;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_FIRST;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && idx_reg == IDX_FIRST)
            b0_reg <= data_byte;
        if (accept && idx_reg == IDX_SECOND)
            b1_reg <= data_byte;
        if (accept && idx_reg == IDX_THIRD)
            pkt_reg <= pkt_next;
    end

endmodule

`default_nettype wire

[rtl/core/pmct_cursor.sv]
// pmct_cursor: limit registers, clamped cursor update and result register
// depends on pmct_pkg; takes decoded packets from pmct_assembler
`default_nettype none

module pmct_cursor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pmct_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pmct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             pkt_valid,
    output logic                                  pkt_ready,
    input  wire pmct_pkg::pkt_t                   pkt,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output pmct_pkg::res_t                        res
);
    import pmct_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic [POS_W-1:0]        max_x_reg, max_y_reg;
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic                    res_valid_reg;
    res_t                    res_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic                    load;

    function automatic logic [POS_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                               input logic [POS_W-1:0] lim);
        logic [POS_W-1:0] r;
        if (v[SUM_W-1])
            r = '0;
        else if (v[SUM_W-2:0] > {1'b0, lim})
            r = lim;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    assign pkt_ready = !res_valid_reg || res_ready;
    assign load      = pkt_valid && pkt_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        sum_x = $signed({2'b00, pos_x_reg}) + SUM_W'(pkt.delta_x);
        // screen y grows downward, mouse y grows upward
        sum_y = $signed({2'b00, pos_y_reg}) - SUM_W'(pkt.delta_y);
        pos_x_next = pkt.x_overflow ? pos_x_reg : clamp(sum_x, max_x_reg);
        pos_y_next = pkt.y_overflow ? pos_y_reg : clamp(sum_y, max_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg     <= MAX_X_RESET;
            max_y_reg     <= MAX_Y_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == CFG_MAX_X)
                max_x_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == CFG_MAX_Y)
                max_y_reg <= cfg_wdata;
            if (load)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            res_valid_reg <= load || (res_valid_reg && !res_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg.pkt      <= pkt;
            res_reg.cursor_x <= pos_x_next;
            res_reg.cursor_y <= pos_y_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ps2_mouse_packet_cursor_tracker_top.sv]
// ps2_mouse_packet_cursor_tracker_top: top level of the ps/2 mouse cursor tracker
// depends on pmct_pkg, pmct_assembler and pmct_cursor
`default_nettype none

// Takes raw ps/2 mouse bytes, one per transfer on the s_axis side, frames them
// into three-byte packets and gives one result transfer on the m_axis side per
// complete packet. A first byte without bit 3 set is dropped and framing waits
// for the next candidate. Each result carries the buttons, overflow flags, the
// two 9-bit signed deltas and the cursor position after the update: x moves by
// delta_x, y by minus delta_y (downward positive), each clamped to 0..max; an
// axis with its overflow flag set keeps its position. A byte is taken in every
// cycle while the output is free or being drained; a packet's result passes the
// packet and then the result register. The cursor starts at 0,0 after reset.
// Limits max_x (index 0, reset 1151) and max_y (index 1, reset 863), set via
// cfg_we/cfg_addr/cfg_wdata, apply from the next complete packet and must be
// written only while no packet is in flight; the block does not enforce this.
module ps2_mouse_packet_cursor_tracker_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [pmct_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pmct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // incoming mouse bytes
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pmct_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] data_byte
    // decoded packets
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] left_button, [1] right_button, [2] middle_button, [3] x_overflow,
    // [4] y_overflow, [13:5] delta_x, [22:14] delta_y, [34:23] cursor_x,
    // [46:35] cursor_y, [47] zero
    output logic [pmct_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import pmct_pkg::*;

    logic pkt_valid;
    logic pkt_ready;
    pkt_t pkt;
    res_t res;

    // framing and decode, ends in the packet register
    pmct_assembler u_assembler (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt)
    );

    // cursor update, ends in the result register
    pmct_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result, first field in the lowest bits
    assign m_axis_tdata = {1'b0,
                           res.cursor_y,
                           res.cursor_x,
                           res.pkt.delta_y,
                           res.pkt.delta_x,
                           res.pkt.y_overflow,
                           res.pkt.x_overflow,
                           res.pkt.middle_button,
                           res.pkt.right_button,
                           res.pkt.left_button};

endmodule

`default_nettype wire

[rtl/core/pmct_checker.sv]
// pmct_checker: port-level checks on the cursor tracker top level
// depends on pmct_pkg; bound to ps2_mouse_packet_cursor_tracker_top
`default_nettype none

module pmct_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [pmct_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import pmct_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with the output free the input side is always open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // a new result follows a byte transfer that passed the packet register,
    // then the result register
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding third byte");

    // pad bit stays clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[OUT_DATA_W-1])
        else $error("pad bit set");

endmodule

bind ps2_mouse_packet_cursor_tracker_top pmct_checker u_pmct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/pmct_motion_checker.sv]
// pmct_motion_checker: watches the byte and result streams of the cursor tracker,
// keeps its own packet framing and cursor state and compares every result
// depends on pmct_pkg for widths, register indexes and first byte bit positions
module pmct_motion_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pmct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pmct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [pmct_pkg::BYTE_W-1:0]        s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [pmct_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 packets_checked,
    output int                                 bytes_dropped
);
    import pmct_pkg::*;

    typedef struct packed {
        logic                      left_btn;
        logic                      right_btn;
        logic                      middle_btn;
        logic                      x_ovf;
        logic                      y_ovf;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [POS_W-1:0]          cursor_x;
        logic [POS_W-1:0]          cursor_y;
    } motion_t;

    motion_t            expected_moves [$];
    byte_idx_t          frame_pos;
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  second_byte;
    logic [POS_W-1:0]   cur_x;
    logic [POS_W-1:0]   cur_y;
    logic [POS_W-1:0]   lim_x;
    logic [POS_W-1:0]   lim_y;
    int                 errs;
    int                 packets;
    int                 drops;

    function automatic logic [POS_W-1:0] clamp_axis(logic [POS_W-1:0] pos, int step,
                                                     logic [POS_W-1:0] lim);
        int v;
        v = int'(pos) + step;
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return v[POS_W-1:0];
    endfunction

    task automatic check_field(string field, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, field, want_v, got_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        motion_t want;
        motion_t got;
        int      step_x;
        int      step_y;
        if (!rst_n)
        begin
            expected_moves.delete();
            frame_pos   = IDX_FIRST;
            first_byte  = '0;
            second_byte = '0;
            cur_x       = '0;
            cur_y       = '0;
            lim_x       = MAX_X_RESET;
            lim_y       = MAX_Y_RESET;
            errs        = 0;
            packets     = 0;
            drops       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_MAX_X)
                    lim_x = cfg_wdata;
                else if (cfg_addr == CFG_MAX_Y)
                    lim_y = cfg_wdata;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                case (frame_pos)
                    IDX_SECOND:
                    begin
                        second_byte = s_axis_tdata;
                        frame_pos   = IDX_THIRD;
                    end
                    IDX_THIRD:
                    begin
                        step_x = first_byte[B0_XSIGN] ? int'(second_byte) - 256
                                                      : int'(second_byte);
                        step_y = first_byte[B0_YSIGN] ? int'(s_axis_tdata) - 256
                                                      : int'(s_axis_tdata);
                        want.left_btn   = first_byte[B0_LEFT];
                        want.right_btn  = first_byte[B0_RIGHT];
                        want.middle_btn = first_byte[B0_MIDDLE];
                        want.x_ovf      = first_byte[B0_XOVF];
                        want.y_ovf      = first_byte[B0_YOVF];
                        want.delta_x    = step_x[DELTA_W-1:0];
                        want.delta_y    = step_y[DELTA_W-1:0];
                        // an axis flagged as overflowed holds its position
                        if (!first_byte[B0_XOVF])
                            cur_x = clamp_axis(cur_x, step_x, lim_x);
                        if (!first_byte[B0_YOVF])
                            cur_y = clamp_axis(cur_y, -step_y, lim_y);
                        want.cursor_x = cur_x;
                        want.cursor_y = cur_y;
                        expected_moves.push_back(want);
                        packets++;
                        frame_pos = IDX_FIRST;
                    end
                    default:
                    begin
                        // a header without the sync bit is thrown away
                        if (s_axis_tdata[B0_SYNC])
                        begin
                            first_byte = s_axis_tdata;
                            frame_pos  = IDX_SECOND;
                        end
                        else
                        begin
                            frame_pos = IDX_FIRST;
                            drops++;
                        end
                    end
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_moves.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got tdata 0x%h",
                             $time, m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want           = expected_moves.pop_front();
                    got.left_btn   = m_axis_tdata[0];
                    got.right_btn  = m_axis_tdata[1];
                    got.middle_btn = m_axis_tdata[2];
                    got.x_ovf      = m_axis_tdata[3];
                    got.y_ovf      = m_axis_tdata[4];
                    got.delta_x    = m_axis_tdata[13:5];
                    got.delta_y    = m_axis_tdata[22:14];
                    got.cursor_x   = m_axis_tdata[34:23];
                    got.cursor_y   = m_axis_tdata[46:35];
                    check_field("left_button", want.left_btn, got.left_btn);
                    check_field("right_button", want.right_btn, got.right_btn);
                    check_field("middle_button", want.middle_btn, got.middle_btn);
                    check_field("x_overflow", want.x_ovf, got.x_ovf);
                    check_field("y_overflow", want.y_ovf, got.y_ovf);
                    check_field("delta_x", int'(want.delta_x), int'(got.delta_x));
                    check_field("delta_y", int'(want.delta_y), int'(got.delta_y));
                    check_field("cursor_x", want.cursor_x, got.cursor_x);
                    check_field("cursor_y", want.cursor_y, got.cursor_y);
                end
            end
        end

        // published a step late so the stimulus side never races the update
        fail_count      <= errs;
        pending         <= expected_moves.size();
        packets_checked <= packets;
        bytes_dropped   <= drops;
    end

endmodule

[dv/ps2_mouse_packet_cursor_tracker_top_tb.sv]
// ps2_mouse_packet_cursor_tracker_top_tb: stimulus and verdict for the cursor tracker
// depends on pmct_pkg, the tracker top level and pmct_motion_checker
module ps2_mouse_packet_cursor_tracker_top_tb;
    import pmct_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;  // far above the slowest legal run
    localparam int PHASE_BYTES   = 150;     // random bytes per limit setting
    localparam int SETTLE_CYCLES = 6;       // extra wait once no result is pending
    localparam int NUM_SETTINGS  = 7;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr      = CFG_MAX_X;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [BYTE_W-1:0]       s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    int fail_count;
    int pending;
    int packets_checked;
    int bytes_dropped;

    // stimulus bookkeeping: where the byte stream stands within a packet
    int stim_pos   = 0;
    int bytes_sent = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold    = 0;
    int cycles     = 0;

    // limit settings per phase, extremes included; entry 5 is drawn at run time
    int lim_x_set [0:NUM_SETTINGS-1] = '{4095, 100, 0, 4095, 0, 1, 1151};
    int lim_y_set [0:NUM_SETTINGS-1] = '{4095, 60, 0, 0, 4095, 1, 863};
    // drift 1 pushes right and down, 2 left and up, 0 leaves the signs random
    int drift_set [0:NUM_SETTINGS-1] = '{1, 0, 2, 1, 2, 0, 1};

    // opening sequence: stray headers, sign and magnitude extremes, every
    // button, both overflow flags alone and together, a clamp at zero
    logic [7:0] opening_bytes [0:25] = '{
        8'h00, 8'hF7,
        8'h08, 8'h00, 8'h00,
        8'h28, 8'hFF, 8'h00,
        8'h0F, 8'hFF, 8'h80,
        8'h38, 8'h00, 8'h00,
        8'h18, 8'h01, 8'hFF,
        8'hFF, 8'hFF, 8'hFF,
        8'h48, 8'h05, 8'h05,
        8'h88, 8'h03, 8'h07
    };

    ps2_mouse_packet_cursor_tracker_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] left, [1] right, [2] middle, [3] x_overflow, [4] y_overflow,
        // [13:5] delta_x, [22:14] delta_y, [34:23] cursor_x, [46:35] cursor_y
        .m_axis_tdata  (m_axis_tdata)
    );

    pmct_motion_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .packets_checked (packets_checked),
        .bytes_dropped   (bytes_dropped)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly no pause, often a short one, now and then a long one
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: ready runs and stalls of random length
    always @(posedge clk or negedge rst_n)
    begin : rx_pacing
        int stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
        end
        else if (rx_stalls_on)
        begin
            stall = pick_len();
            m_axis_tready <= (stall == 0);
            rx_hold       <= (stall == 0) ? $urandom_range(0, 5) : stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("ps2_mouse_packet_cursor_tracker_top: mismatch");
            $finish;
        end
    end

    // one byte transfer; valid stays high into the next byte unless a gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gaps_on ? pick_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        bytes_sent++;
        // keep track of framing so phases end on a packet boundary
        if (stim_pos == 0)
            stim_pos = b[B0_SYNC] ? 1 : 0;
        else
            stim_pos = (stim_pos + 1) % 3;
    endtask

    // let every expected result drain, then allow for a packet still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both limits in back-to-back write cycles, enable held across them
    task automatic write_limits(input int lx, input int ly);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_X;
        cfg_wdata <= lx[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr  <= CFG_MAX_Y;
        cfg_wdata <= ly[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0] head;
        logic       x_sign;
        logic       y_sign;
        int         phase_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening phase runs on the reset limits
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        while (stim_pos != 0)
            send_byte(8'h00);
        settle();

        lim_x_set[5] = $urandom_range(1, 4094);
        lim_y_set[5] = $urandom_range(1, 4094);

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            // vary pacing so some phases run flat out on one side
            tx_gaps_on   = (ph % 3) != 1;
            rx_stalls_on <= (ph % 4) != 2;
            write_limits(lim_x_set[ph], lim_y_set[ph]);

            // overflow on both axes first: a position above a lowered max holds
            send_byte({2'b11, 2'($urandom_range(0, 3)), 1'b1, 3'($urandom_range(0, 7))});
            send_byte(8'($urandom));
            send_byte(8'($urandom));

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if (stim_pos == 0 && $urandom_range(0, 99) < 85)
                begin
                    x_sign = 1'($urandom);
                    y_sign = 1'($urandom);
                    if (drift_set[ph] != 0 && $urandom_range(0, 3) != 0)
                    begin
                        x_sign = (drift_set[ph] == 2);
                        y_sign = (drift_set[ph] == 1);
                    end
                    head = {($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0),
                            y_sign, x_sign, 1'b1, 3'($urandom_range(0, 7))};
                    send_byte(head);
                    send_byte(8'($urandom));
                    send_byte(8'($urandom));
                end
                else
                begin
                    // noise: a stray header, or a misframed packet when bit 3 is set
                    send_byte(8'($urandom));
                end
            end
            while (stim_pos != 0)
                send_byte(8'($urandom));
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d mouse bytes over %0d limit settings, both axes at 0 and 4095",
                 bytes_sent, NUM_SETTINGS + 1);
        $display("%0d packets checked, %0d headers without sync dropped",
                 packets_checked, bytes_dropped);
        if (fail_count == 0 && pending == 0)
            $display("ps2_mouse_packet_cursor_tracker_top: match");
        else
            $display("ps2_mouse_packet_cursor_tracker_top: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/core/pmct_pkg.sv
rtl/core/pmct_assembler.sv
rtl/core/pmct_cursor.sv
rtl/core/ps2_mouse_packet_cursor_tracker_top.sv
rtl/core/pmct_checker.sv
dv/pmct_motion_checker.sv
dv/ps2_mouse_packet_cursor_tracker_top_tb.sv
